// ----- rtl/kpi_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyframe position interpolator package
// Shared codes and constants for the keyframe track and its query logic.
// ----------------------------------------------------------------------------
package kpi_pkg;

   // Request actions.
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   // Response status codes.
   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;
   localparam logic [1:0] STS_ORDER = 2'd3;

   // Register indexes.
   localparam logic CSR_TICKS_PER_SEC = 1'b0;
   localparam logic CSR_DURATION      = 1'b1;

   // Register reset values (25.0 ticks per second, 100.0 ticks long).
   localparam logic [31:0] TPS_RESET = 32'd1638400;
   localparam logic [31:0] DUR_RESET = 32'd6553600;

   // Interpolation step magnitude cap, and the divider's step count.
   localparam logic [48:0] MAG_CAP   = 49'h4_0000_0000;
   localparam logic [5:0]  DIV_LAST  = 6'd47;

   // One key's position: x in entry 0, y in entry 1, z in entry 2.
   typedef logic [2:0][31:0] pos_type;

endpackage

// ----- rtl/kpi_req_if.sv -----
// ----------------------------------------------------------------------------
// Keyframe request channel
// Valid/ready channel that carries clear, append and query requests.
// ----------------------------------------------------------------------------
interface kpi_req_if;

   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] key_time;
   logic [31:0] key_x;
   logic [31:0] key_y;
   logic [31:0] key_z;
   logic [31:0] query_seconds;

   modport source (output valid, action, key_time, key_x, key_y, key_z, query_seconds,
                   input ready);
   modport sink   (input valid, action, key_time, key_x, key_y, key_z, query_seconds,
                   output ready);

endinterface

// ----- rtl/kpi_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Keyframe response channel
// Valid/ready channel that carries one result beat per request.
// ----------------------------------------------------------------------------
interface kpi_rsp_if;

   logic        valid;
   logic        ready;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;
   logic [31:0] tick_time;
   logic [1:0]  status;
   logic [8:0]  stored_keys;

   modport source (output valid, pos_x, pos_y, pos_z, tick_time, status, stored_keys,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, tick_time, status, stored_keys,
                   output ready);

endinterface

// ----- rtl/keyframe_position_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// Keyframe position interpolator
// One bone's position key track in block memory, with a query that wraps
// the time, binary-searches the keys and interpolates linearly.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake          Contents
//   req_if    in          valid/ready        action, key time/position, seconds
//   rsp_if    out         valid/ready        position, tick time, status, count
//   csr_*     in          write enable       ticks per second, duration
//
// Clear and unused actions go straight to the response; an append first reads
// back the last key time. A query converts seconds to ticks, takes the modulo by
// the duration (skipped when it is zero), runs search probes (at most eight, one
// key memory read each), fetches the keys, on interpolation divides for the
// fraction and steps each axis on the shared 32x32 multiplier, then hands off.
// Reset is synchronous; it empties the track and loads the register defaults.
// The response sits in an output register; a stalled response only holds the
// next item in its hand-off state, and a new request is taken while it waits.
//
module keyframe_position_interpolator_unit import kpi_pkg::*; #(
   parameter int MAX_KEYS = 256
) (
   input  logic        clock,
   input  logic        reset,
   kpi_req_if.sink     req_if,
   kpi_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);

   typedef enum logic [13:0] {
      S_IDLE = 14'b00000000000001,
      S_APP  = 14'b00000000000010,
      S_MUL  = 14'b00000000000100,
      S_MOD  = 14'b00000000001000,
      S_SRCH = 14'b00000000010000,
      S_SCMP = 14'b00000000100000,
      S_FHI  = 14'b00000001000000,
      S_FDEC = 14'b00000010000000,
      S_DIV  = 14'b00000100000000,
      S_LD   = 14'b00001000000000,
      S_LLO  = 14'b00010000000000,
      S_LHI  = 14'b00100000000000,
      S_LSUM = 14'b01000000000000,
      S_RESP = 14'b10000000000000
   } state_type;

   // Control registers.
   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] tps_ff, tps_in;
   logic [31:0] dur_ff, dur_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Request and work registers.
   logic [31:0] ktime_ff, ktime_in;
   pos_type     kpos_ff, kpos_in;
   logic [31:0] qs_ff, qs_in;
   logic [31:0] tick_ff, tick_in;
   logic [1:0]  status_ff, status_in;
   pos_type     pos_ff, pos_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [31:0] tlo_ff, tlo_in;
   pos_type     poslo_ff, poslo_in, poshi_ff, poshi_in;
   logic        fneg_ff, fneg_in;
   logic [1:0]  axis_ff, axis_in;
   logic [31:0] dm_ff, dm_in;
   logic        neg_ff, neg_in;
   logic [31:0] a_ff, a_in;
   logic [63:0] plo_ff, plo_in;
   logic [47:0] phi_ff, phi_in;

   // Shared divider registers.
   logic [47:0] div_dvd_ff, div_dvd_in;
   logic [31:0] div_rem_ff, div_rem_in;
   logic [47:0] div_q_ff, div_q_in;
   logic [31:0] div_dsr_ff, div_dsr_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;

   // Response registers.
   pos_type     rsp_pos_ff, rsp_pos_in;
   logic [31:0] rsp_tick_ff, rsp_tick_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [8:0]  rsp_keys_ff, rsp_keys_in;

   // Key memories.
   logic [31:0] time_mem [MAX_KEYS];
   pos_type     pos_mem [MAX_KEYS];
   logic [31:0] rd_time_ff;
   pos_type     rd_pos_ff;
   logic        mem_we;
   logic [AW-1:0] mem_wa, mem_ra;

   // Datapath helpers.
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [32:0] div_trial;
   logic        div_ge;
   logic [31:0] div_rem_nx;
   logic [47:0] div_q_nx;
   logic [CW-1:0] cnt_m1, mid_calc;
   logic [CW:0] lo_p1;
   logic [32:0] diff_t, diff_p;
   logic [31:0] nm;
   logic [48:0] mag_sum;
   logic [34:0] mag_c;
   logic [35:0] sum_r;
   logic [31:0] sat_r;
   logic [CW+8:0] keys_ext;

   assign req_if.ready = (state_ff == S_IDLE);

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.pos_x       = rsp_pos_ff[0];
   assign rsp_if.pos_y       = rsp_pos_ff[1];
   assign rsp_if.pos_z       = rsp_pos_ff[2];
   assign rsp_if.tick_time   = rsp_tick_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.stored_keys = rsp_keys_ff;

   // Shared multiplier: tick conversion, then the two halves of each axis step.
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // One restoring division step per cycle.
   assign div_trial  = {div_rem_ff, div_dvd_ff[47]};
   assign div_ge     = (div_trial >= {1'b0, div_dsr_ff});
   assign div_rem_nx = div_ge ? 32'(div_trial - {1'b0, div_dsr_ff}) : div_trial[31:0];
   assign div_q_nx   = {div_q_ff[46:0], div_ge};

   // Search arithmetic.
   assign cnt_m1   = count_ff - CW'(1);
   assign lo_p1    = {1'b0, lo_ff} + (CW+1)'(1);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);

   // Signed distance from the lower key to the query tick.
   assign diff_t = {1'b0, tick_ff} - {1'b0, tlo_ff};
   assign nm     = diff_t[32] ? 32'(-diff_t) : diff_t[31:0];

   // Axis difference for the current axis.
   assign diff_p = {poshi_ff[axis_ff][31], poshi_ff[axis_ff]}
                 - {poslo_ff[axis_ff][31], poslo_ff[axis_ff]};

   // Step magnitude from both partial products, capped, then saturated add.
   assign mag_sum = {16'b0, phi_ff[16:0], 16'b0} + {1'b0, plo_ff[63:16]};
   assign mag_c   = ((|phi_ff[47:17]) || (mag_sum > MAG_CAP)) ? MAG_CAP[34:0]
                                                            : mag_sum[34:0];
   assign sum_r   = neg_ff ? ({{4{a_ff[31]}}, a_ff} - {1'b0, mag_c})
                           : ({{4{a_ff[31]}}, a_ff} + {1'b0, mag_c});
   always_comb begin
      if (sum_r[35] && (sum_r[35:31] != 5'b11111)) begin
         sat_r = 32'h8000_0000;
      end else if (!sum_r[35] && (sum_r[35:31] != 5'b00000)) begin
         sat_r = 32'h7FFF_FFFF;
      end else begin
         sat_r = sum_r[31:0];
      end
   end

   assign keys_ext = (CW+9)'(count_ff);

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      tps_in       = tps_ff;
      dur_in       = dur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      ktime_in     = ktime_ff;
      kpos_in      = kpos_ff;
      qs_in        = qs_ff;
      tick_in      = tick_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      tlo_in       = tlo_ff;
      poslo_in     = poslo_ff;
      poshi_in     = poshi_ff;
      fneg_in      = fneg_ff;
      axis_in      = axis_ff;
      dm_in        = dm_ff;
      neg_in       = neg_ff;
      a_in         = a_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      div_dvd_in   = div_dvd_ff;
      div_rem_in   = div_rem_ff;
      div_q_in     = div_q_ff;
      div_dsr_in   = div_dsr_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_tick_in   = rsp_tick_ff;
      rsp_status_in = rsp_status_ff;
      rsp_keys_in   = rsp_keys_ff;
      mem_we       = 1'b0;
      mem_wa       = count_ff[AW-1:0];
      mem_ra       = lo_ff[AW-1:0];
      mul_a        = dm_ff;
      mul_b        = div_q_ff[31:0];

      // Register writes.
      if (csr_wr_en && (csr_index == CSR_TICKS_PER_SEC)) begin
         tps_in = csr_wdata;
      end
      if (csr_wr_en && (csr_index == CSR_DURATION)) begin
         dur_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            mem_ra = cnt_m1[AW-1:0];
            if (req_if.valid) begin
               ktime_in  = req_if.key_time;
               kpos_in   = {req_if.key_z, req_if.key_y, req_if.key_x};
               qs_in     = req_if.query_seconds;
               tick_in   = '0;
               status_in = STS_OK;
               pos_in    = '0;
               unique case (req_if.action)
                  ACT_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  ACT_APPEND: begin
                     if (count_ff == CW'(MAX_KEYS)) begin
                        status_in = STS_FULL;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_APP;
                     end
                  end
                  ACT_QUERY: begin
                     state_in = S_MUL;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // Last key time is now read back; check the order and store.
         S_APP: begin
            if ((count_ff != '0) && (ktime_ff <= rd_time_ff)) begin
               status_in = STS_ORDER;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
            end
            state_in = S_RESP;
         end

         // Seconds to ticks, then start the modulo by the duration.
         S_MUL: begin
            mul_a = qs_ff;
            mul_b = tps_ff;
            div_dvd_in = mul_p[63:16];
            div_rem_in = '0;
            div_q_in   = '0;
            div_dsr_in = dur_ff;
            div_cnt_in = DIV_LAST;
            if (dur_ff == '0) begin
               tick_in = mul_p[47:16];
               lo_in   = '0;
               hi_in   = count_ff;
               if (count_ff == '0) begin
                  status_in = STS_EMPTY;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SRCH;
               end
            end else begin
               state_in = S_MOD;
            end
         end

         S_MOD: begin
            div_dvd_in = div_dvd_ff << 1;
            div_rem_in = div_rem_nx;
            div_q_in   = div_q_nx;
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == '0) begin
               tick_in = div_rem_nx;
               lo_in   = '0;
               hi_in   = count_ff;
               if (count_ff == '0) begin
                  status_in = STS_EMPTY;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SRCH;
               end
            end
         end

         // Probe the middle key, or fetch the lower key once the range is one.
         S_SRCH: begin
            if (lo_p1 < {1'b0, hi_ff}) begin
               mid_in   = mid_calc;
               mem_ra   = mid_calc[AW-1:0];
               state_in = S_SCMP;
            end else begin
               mem_ra   = lo_ff[AW-1:0];
               state_in = S_FHI;
            end
         end

         S_SCMP: begin
            if (rd_time_ff < tick_ff) begin
               lo_in = mid_ff;
            end else if (rd_time_ff > tick_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff;
               hi_in = mid_ff + CW'(1);
            end
            state_in = S_SRCH;
         end

         // Lower key arrives; fetch the upper key.
         S_FHI: begin
            tlo_in   = rd_time_ff;
            poslo_in = rd_pos_ff;
            mem_ra   = hi_ff[AW-1:0];
            state_in = S_FDEC;
         end

         // Exact hit or past the end returns the lower key, else start the fraction.
         S_FDEC: begin
            if ((tlo_ff == tick_ff) || (hi_ff == count_ff)) begin
               pos_in   = poslo_ff;
               state_in = S_RESP;
            end else begin
               poshi_in   = rd_pos_ff;
               fneg_in    = diff_t[32];
               div_dvd_in = {nm, 16'b0};
               div_rem_in = '0;
               div_q_in   = '0;
               div_dsr_in = rd_time_ff - tlo_ff;
               div_cnt_in = DIV_LAST;
               axis_in    = '0;
               state_in   = S_DIV;
            end
         end

         S_DIV: begin
            div_dvd_in = div_dvd_ff << 1;
            div_rem_in = div_rem_nx;
            div_q_in   = div_q_nx;
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == '0) begin
               state_in = S_LD;
            end
         end

         // Per axis: difference, two partial products, saturated sum.
         S_LD: begin
            dm_in    = diff_p[32] ? 32'(-diff_p) : diff_p[31:0];
            neg_in   = diff_p[32] ^ fneg_ff;
            a_in     = poslo_ff[axis_ff];
            state_in = S_LLO;
         end

         S_LLO: begin
            mul_b    = div_q_ff[31:0];
            plo_in   = mul_p;
            state_in = S_LHI;
         end

         S_LHI: begin
            mul_b    = {16'b0, div_q_ff[47:32]};
            phi_in   = mul_p[47:0];
            state_in = S_LSUM;
         end

         S_LSUM: begin
            pos_in[axis_ff] = sat_r;
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               state_in = S_RESP;
            end else begin
               state_in = S_LD;
            end
         end

         // Hand the result to the output register once it is free.
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_pos_in    = pos_ff;
               rsp_tick_in   = tick_ff;
               rsp_status_in = status_ff;
               rsp_keys_in   = keys_ext[8:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         tps_ff       <= TPS_RESET;
         dur_ff       <= DUR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tps_ff       <= tps_in;
         dur_ff       <= dur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ktime_ff      <= ktime_in;
      kpos_ff       <= kpos_in;
      qs_ff         <= qs_in;
      tick_ff       <= tick_in;
      status_ff     <= status_in;
      pos_ff        <= pos_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      tlo_ff        <= tlo_in;
      poslo_ff      <= poslo_in;
      poshi_ff      <= poshi_in;
      fneg_ff       <= fneg_in;
      axis_ff       <= axis_in;
      dm_ff         <= dm_in;
      neg_ff        <= neg_in;
      a_ff          <= a_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      div_dvd_ff    <= div_dvd_in;
      div_rem_ff    <= div_rem_in;
      div_q_ff      <= div_q_in;
      div_dsr_ff    <= div_dsr_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_tick_ff   <= rsp_tick_in;
      rsp_status_ff <= rsp_status_in;
      rsp_keys_ff   <= rsp_keys_in;
   end

   // Key memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[mem_wa] <= ktime_ff;
         pos_mem[mem_wa]  <= kpos_ff;
      end
      rd_time_ff <= time_mem[mem_ra];
      rd_pos_ff  <= pos_mem[mem_ra];
   end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Keyframe position interpolator testbench
// Drives clear, append and query beats into the key track, and predicts each
// response from a local copy of the track and the registers. Every response
// is checked field by field against the oldest prediction. A directed table
// is followed by random track builds under several register settings and
// idle patterns.
// ----------------------------------------------------------------------------
module tb;
   import kpi_pkg::*;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] key_time;
      logic [31:0] key_x;
      logic [31:0] key_y;
      logic [31:0] key_z;
      logic [31:0] query_seconds;
   } request_type;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] tick_time;
      logic [1:0]  status;
      logic [8:0]  stored_keys;
   } position_type;

   // One directed row; typed rows carry a status and key count read off directly.
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] key_time;
      logic [31:0] key_x;
      logic [31:0] key_y;
      logic [31:0] key_z;
      logic [31:0] query_seconds;
      logic        typed;
      logic [1:0]  status;
      logic [8:0]  stored_keys;
   } table_row_type;

   localparam int TRACK_DEPTH = 256;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_BEATS = 40;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_index;
   logic [31:0] csr_wdata;

   kpi_req_if req_if ();
   kpi_rsp_if rsp_if ();

   keyframe_position_interpolator_unit #(.MAX_KEYS(TRACK_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the track and the registers.
   logic [31:0] track_times [TRACK_DEPTH];
   logic [31:0] track_pos [TRACK_DEPTH][3];
   int unsigned track_count;
   logic [31:0] tick_rate;
   logic [31:0] span_ticks;

   position_type expected_positions[$];
   int  fail_count;
   int  idle_mode;
   int  hold_cycles;
   int  quiet_cycles;
   int  beats_sent;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // One axis: a + sign * floor(|b - a| * |f| / 2^16), capped and saturated.
   function automatic logic [31:0] blend_axis(logic [31:0] a, logic [31:0] b, bit fneg,
                                              logic [63:0] fmag);
      longint d;
      longint r;
      bit neg;
      logic [63:0] dm;
      logic [63:0] plo;
      logic [63:0] phi;
      logic [63:0] mag;
      d = longint'($signed(b)) - longint'($signed(a));
      neg = (d < 0) != fneg;
      dm = (d < 0) ? 64'(-d) : 64'(d);
      plo = dm * {32'd0, fmag[31:0]};
      phi = dm * (fmag >> 32);
      if (phi >= 64'h2_0000) begin
         mag = 64'h4_0000_0000;
      end else begin
         mag = (phi << 16) + (plo >> 16);
         if (mag > 64'h4_0000_0000) mag = 64'h4_0000_0000;
      end
      r = neg ? longint'($signed(a)) - longint'(mag) : longint'($signed(a)) + longint'(mag);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   // Applies one beat to the local track and returns the position it yields.
   function automatic position_type predict_position(request_type r);
      position_type p;
      logic [63:0] ticks;
      logic [63:0] den;
      logic [63:0] nm;
      logic [63:0] fmag;
      longint num;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      p = '0;
      if (r.action == ACT_CLEAR) begin
         track_count = 0;
      end else if (r.action == ACT_APPEND) begin
         if (track_count >= TRACK_DEPTH) begin
            p.status = STS_FULL;
         end else if (track_count > 0 && r.key_time <= track_times[track_count - 1]) begin
            p.status = STS_ORDER;
         end else begin
            track_times[track_count] = r.key_time;
            track_pos[track_count][0] = r.key_x;
            track_pos[track_count][1] = r.key_y;
            track_pos[track_count][2] = r.key_z;
            track_count++;
         end
      end else if (r.action == ACT_QUERY) begin
         ticks = ({32'd0, r.query_seconds} * {32'd0, tick_rate}) >> 16;
         p.tick_time = (span_ticks == 0) ? ticks[31:0] : 32'(ticks % {32'd0, span_ticks});
         if (track_count == 0) begin
            p.status = STS_EMPTY;
         end else begin
            lo = 0;
            hi = track_count;
            while (lo + 1 < hi) begin
               mid = lo + (hi - lo) / 2;
               if (track_times[mid] < p.tick_time) begin
                  lo = mid;
               end else if (track_times[mid] > p.tick_time) begin
                  hi = mid;
               end else begin
                  lo = mid;
                  hi = mid + 1;
               end
            end
            if (track_times[lo] == p.tick_time || hi >= track_count) begin
               p.pos_x = track_pos[lo][0];
               p.pos_y = track_pos[lo][1];
               p.pos_z = track_pos[lo][2];
            end else begin
               num = longint'({32'd0, p.tick_time}) - longint'({32'd0, track_times[lo]});
               den = {32'd0, track_times[hi]} - {32'd0, track_times[lo]};
               nm = (num < 0) ? 64'(-num) : 64'(num);
               fmag = (nm << 16) / den;
               p.pos_x = blend_axis(track_pos[lo][0], track_pos[hi][0], num < 0, fmag);
               p.pos_y = blend_axis(track_pos[lo][1], track_pos[hi][1], num < 0, fmag);
               p.pos_z = blend_axis(track_pos[lo][2], track_pos[hi][2], num < 0, fmag);
            end
         end
      end
      p.stored_keys = 9'(track_count);
      return p;
   endfunction

   // Offers one beat, with random gaps ahead of it, and records its prediction.
   task automatic send_beat(request_type r, bit typed = 1'b0, position_type typed_exp = '0);
      int pct;
      position_type p;
      pct = (idle_mode == 0) ? 23 : (idle_mode == 1) ? 57 : 0;
      while ($urandom_range(99) < pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.action        <= r.action;
      req_if.key_time      <= r.key_time;
      req_if.key_x         <= r.key_x;
      req_if.key_y         <= r.key_y;
      req_if.key_z         <= r.key_z;
      req_if.query_seconds <= r.query_seconds;
      do @(posedge clock); while (!req_if.ready);
      p = predict_position(r);
      expected_positions = {expected_positions, (typed ? typed_exp : p)};
      beats_sent++;
   endtask

   // Lowers valid and waits for every outstanding response.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write; only called with the block drained.
   task automatic write_reg(logic index, logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_TICKS_PER_SEC) tick_rate = value;
      else span_ticks = value;
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(131072)) - 65536);
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      endcase
   endfunction

   // Builds a fresh track of increasing keys and queries it, with some noise.
   task automatic build_track(int nkeys);
      request_type r;
      logic [31:0] t;
      logic [31:0] step;
      int nq;
      r = '0;
      r.action = ACT_CLEAR;
      r.key_time = $urandom;
      send_beat(r);
      t = ($urandom_range(1)) ? $urandom_range(1 << 20) : $urandom;
      step = 32'd1 << $urandom_range(20);
      for (int k = 0; k < nkeys; k++) begin
         r.action = ACT_APPEND;
         r.key_time = t;
         r.key_x = random_coord();
         r.key_y = random_coord();
         r.key_z = random_coord();
         r.query_seconds = $urandom;
         // Now and then a key time pulled back, which may break the order.
         if ($urandom_range(15) == 0 && k > 0) r.key_time = t - 32'($urandom_range(step));
         send_beat(r);
         t = t + 32'($urandom_range(step, 1));
      end
      nq = $urandom_range(8, 2);
      for (int q = 0; q < nq; q++) begin
         r = '0;
         r.action = ACT_QUERY;
         if (tick_rate == 32'h1_0000 && track_count > 0 && $urandom_range(3) != 0) begin
            // Land on, near, or around the stored keys.
            r.query_seconds = track_times[$urandom_range(track_count - 1)] +
                              32'($signed($urandom_range(2 * step)) - $signed(step));
            if ($urandom_range(3) == 0)
               r.query_seconds = track_times[$urandom_range(track_count - 1)];
         end else begin
            r.query_seconds = $urandom;
         end
         r.key_time = $urandom;
         send_beat(r);
         if ($urandom_range(9) == 0) begin
            r.action = ACT_NONE;
            r.key_x = $urandom;
            send_beat(r);
         end
      end
   endtask

   // Response ready and the response checker.
   always @(posedge clock) begin
      position_type want;
      int pct;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_positions.size() == 0) begin
            $error("response with no prediction waiting");
            fail_count++;
         end else begin
            want = expected_positions.pop_front();
            if (rsp_if.pos_x !== want.pos_x) begin
               $error("pos_x expected %h actual %h", want.pos_x, rsp_if.pos_x);
               fail_count++;
            end
            if (rsp_if.pos_y !== want.pos_y) begin
               $error("pos_y expected %h actual %h", want.pos_y, rsp_if.pos_y);
               fail_count++;
            end
            if (rsp_if.pos_z !== want.pos_z) begin
               $error("pos_z expected %h actual %h", want.pos_z, rsp_if.pos_z);
               fail_count++;
            end
            if (rsp_if.tick_time !== want.tick_time) begin
               $error("tick_time expected %h actual %h", want.tick_time, rsp_if.tick_time);
               fail_count++;
            end
            if (rsp_if.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_if.status);
               fail_count++;
            end
            if (rsp_if.stored_keys !== want.stored_keys) begin
               $error("stored_keys expected %0d actual %0d", want.stored_keys,
                      rsp_if.stored_keys);
               fail_count++;
            end
         end
      end
      pct = (idle_mode == 0) ? 57 : (idle_mode == 1) ? 23 : 0;
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= pct);
      end
   end

   // Watchdog: cycles with no beat accepted on either channel.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_wr_en ||
          reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Directed rows, then random track builds under several register settings.
   initial begin
      table_row_type rows [21];
      request_type r;
      position_type typed_exp;
      logic [31:0] tps_list [6];
      logic [31:0] dur_list [6];
      int phase_start;

      rows = '{
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, STS_EMPTY, 9'd0},
         '{ACT_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF, 1'b1, STS_OK, 9'd0},
         '{ACT_APPEND, 32'h0010_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
           1'b0, STS_OK, 9'd0},
         '{ACT_APPEND, 32'h0010_0000, 32'h1, 32'h1, 32'h1, 32'h0, 1'b1, STS_ORDER, 9'd1},
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, STS_OK, 9'd0},
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, STS_OK, 9'd0},
         '{ACT_APPEND, 32'h0020_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,
           1'b0, STS_OK, 9'd0},
         '{ACT_APPEND, 32'h0040_0000, 32'h0, 32'h1234_5678, 32'h8000_0000, 32'h0,
           1'b0, STS_OK, 9'd0},
         '{ACT_APPEND, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, STS_ORDER, 9'd3},
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, STS_OK, 9'd0},
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_A3D7, 1'b0, STS_OK, 9'd0},
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0, STS_OK, 9'd0},
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0002_8F5C, 1'b0, STS_OK, 9'd0},
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0002_0000, 1'b0, STS_OK, 9'd0},
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 1'b0, STS_OK, 9'd0},
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0004_0000, 1'b0, STS_OK, 9'd0},
         '{ACT_CLEAR,  32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, STS_OK, 9'd0},
         '{ACT_APPEND, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
           1'b0, STS_OK, 9'd0},
         '{ACT_APPEND, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, STS_ORDER, 9'd1},
         '{ACT_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0, STS_OK, 9'd0},
         '{ACT_CLEAR,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, STS_OK, 9'd0}
      };
      tps_list = '{32'h1_0000, 32'h1_0000, 32'd1, 32'hFFFF_FFFF, 32'h1_0000, 32'h0};
      dur_list = '{32'hFFFF_FFFF, 32'h0100_0000, 32'd1, 32'hFFFF_FFFF, 32'h0, 32'h0};

      // Known values on every input from time zero.
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_TICKS_PER_SEC;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.action = ACT_NONE;
      req_if.key_time = '0;
      req_if.key_x = '0;
      req_if.key_y = '0;
      req_if.key_z = '0;
      req_if.query_seconds = '0;
      rsp_if.ready = 1'b0;
      fail_count = 0;
      idle_mode = 0;
      hold_cycles = 0;
      quiet_cycles = 0;
      beats_sent = 0;
      track_count = 0;
      tick_rate = TPS_RESET;
      span_ticks = DUR_RESET;
      phase_start = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table under the reset register values.
      foreach (rows[i]) begin
         r = '{rows[i].action, rows[i].key_time, rows[i].key_x, rows[i].key_y,
               rows[i].key_z, rows[i].query_seconds};
         typed_exp = '0;
         typed_exp.status = rows[i].status;
         typed_exp.stored_keys = rows[i].stored_keys;
         send_beat(r, rows[i].typed, typed_exp);
      end

      // Random phases: two per idle pattern, each with its own register setting.
      // The fifth phase runs with a zero duration, so ticks are not wrapped.
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         idle_mode = ph / 2;
         if (ph == 5) begin
            tps_list[5] = $urandom_range(32'h0040_0000, 1);
            dur_list[5] = $urandom_range(32'h0800_0000, 1);
         end
         write_reg(CSR_TICKS_PER_SEC, tps_list[ph]);
         write_reg(CSR_DURATION, dur_list[ph]);
         if (ph == 1) begin
            // Fill the track to the top while the response side holds off.
            hold_cycles = 600;
            build_track(TRACK_DEPTH + 2);
         end
         phase_start = beats_sent;
         while (beats_sent < phase_start + PHASE_BEATS) begin
            build_track($urandom_range(7) == 0 ? $urandom_range(40, 12) : $urandom_range(6));
            if (ph == 3 && $urandom_range(3) == 0) drain();
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_positions.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
